@@ design/sha256_pkg.sv @@
// Shared types, constants and functions of the SHA-256 hash engine.
package sha256_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned FifoDepthDef = 4;
  localparam logic [3:0]  LenPos       = 4'd14;

  localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One block word handed from the padding front end to the compression back end.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start;
    logic             last;
  } blk_word_t;

  typedef enum logic [4:0] {
    FRONT_IDLE  = 5'b00001,
    FRONT_PAD80 = 5'b00010,
    FRONT_ZERO  = 5'b00100,
    FRONT_LENHI = 5'b01000,
    FRONT_LENLO = 5'b10000
  } front_state_e;

  typedef enum logic [3:0] {
    BACK_LOAD  = 4'b0001,
    BACK_ROUND = 4'b0010,
    BACK_ADD   = 4'b0100,
    BACK_EMIT  = 4'b1000
  } back_state_e;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ design/sha256_if.sv @@
// Request and digest channel interfaces of the SHA-256 hash engine.
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        message_start;
  logic        message_end;

  modport source (output valid, message_word, valid_bytes, message_start, message_end,
                  input ready);
  modport sink (input valid, message_word, valid_bytes, message_start, message_end,
                output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/sha256_front.sv @@
// Front end: takes message requests, counts length and generates padded block words.
module sha256_front import sha256_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  message_word_i,
  input  logic [2:0]        valid_bytes_i,
  input  logic              message_start_i,
  input  logic              message_end_i,
  output logic              push_o,
  output blk_word_t         push_data_o,
  input  logic              full_i
);

  front_state_e state_q, state_d;
  logic [3:0]   pos_q, pos_d;
  logic [63:0]  len_q, len_d;
  logic [3:0]   pos_base;
  logic [63:0]  len_base;
  logic [63:0]  bits;
  logic [2:0]   nbytes;
  logic [WordW-1:0] tail_word;

  assign pos_base = message_start_i ? 4'd0 : pos_q;
  assign len_base = message_start_i ? 64'd0 : len_q;
  assign nbytes   = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
  assign bits     = len_q << 3;

  // Final word with the pad byte placed right after the counted bytes; a full four-byte word passes unchanged.
  always_comb begin
    unique case (nbytes)
      3'd0:    tail_word = PadWord;
      3'd1:    tail_word = {message_word_i[31:24], 24'h80_0000};
      3'd2:    tail_word = {message_word_i[31:16], 16'h8000};
      3'd3:    tail_word = {message_word_i[31:8], 8'h80};
      default: tail_word = message_word_i;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    len_d       = len_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_data_o = '{word: '0, start: 1'b0, last: 1'b0};
    unique case (state_q)
      FRONT_IDLE: begin
        in_ready_o = !full_i;
        push_data_o.start = message_start_i;
        if (in_valid_i && !full_i) begin
          push_o = 1'b1;
          pos_d  = pos_base + 4'd1;
          if (message_end_i) begin
            push_data_o.word = tail_word;
            len_d   = len_base + 64'(nbytes);
            state_d = (nbytes == 3'd4) ? FRONT_PAD80 : FRONT_ZERO;
          end else begin
            push_data_o.word = message_word_i;
            len_d = len_base + 64'd4;
          end
        end
      end
      FRONT_PAD80: begin
        push_data_o.word = PadWord;
        if (!full_i) begin
          push_o  = 1'b1;
          pos_d   = pos_q + 4'd1;
          state_d = FRONT_ZERO;
        end
      end
      FRONT_ZERO: begin
        if (pos_q == LenPos) begin
          state_d = FRONT_LENHI;
        end else if (!full_i) begin
          push_o = 1'b1;
          pos_d  = pos_q + 4'd1;
        end
      end
      FRONT_LENHI: begin
        push_data_o.word = bits[63:32];
        if (!full_i) begin
          push_o  = 1'b1;
          pos_d   = pos_q + 4'd1;
          state_d = FRONT_LENLO;
        end
      end
      FRONT_LENLO: begin
        push_data_o.word = bits[31:0];
        push_data_o.last = 1'b1;
        if (!full_i) begin
          push_o  = 1'b1;
          pos_d   = 4'd0;
          len_d   = 64'd0;
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      pos_q   <= 4'd0;
      len_q   <= 64'd0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

endmodule

@@ design/sha256_fifo.sv @@
// Short queue of block words between the front and back ends.
module sha256_fifo import sha256_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  blk_word_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output blk_word_t pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_word_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/sha256_back.sv @@
// Back end: collects block words, runs 64 compression rounds, emits the digest.
module sha256_back import sha256_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  blk_word_t        pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  back_state_e      state_q, state_d;
  logic [3:0]       cnt_q;
  logic [3:0]       cnt_base;
  logic [5:0]       rnd_q;
  logic [2:0]       idx_q;
  logic             final_q;
  logic [WordW-1:0] hash_q [8];
  logic [WordW-1:0] var_q  [8];
  logic [WordW-1:0] win_q  [16];
  logic             ov_q;
  logic [WordW-1:0] od_q;
  logic [2:0]       oi_q;
  logic             ol_q;
  logic             emit_go;
  logic [WordW-1:0] ws, t1, t2, ch, maj;

  assign pop_o    = (state_q == BACK_LOAD) && !empty_i;
  assign cnt_base = pop_data_i.start ? 4'd0 : cnt_q;
  assign emit_go  = (state_q == BACK_EMIT) && (!ov_q || out_ready_i);

  // Next schedule word from the sliding sixteen-word window.
  assign ws  = win_q[0] + sml_sig0(win_q[1]) + win_q[9] + sml_sig1(win_q[14]);
  assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
  assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
  assign t1  = var_q[7] + big_sig1(var_q[4]) + ch + RoundK[rnd_q] + win_q[0];
  assign t2  = big_sig0(var_q[0]) + maj;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_LOAD:  if (pop_o && cnt_base == 4'd15) state_d = BACK_ROUND;
      BACK_ROUND: if (rnd_q == 6'd63) state_d = BACK_ADD;
      BACK_ADD:   state_d = final_q ? BACK_EMIT : BACK_LOAD;
      BACK_EMIT:  if (emit_go && idx_q == 3'd7) state_d = BACK_LOAD;
      default:    state_d = BACK_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_LOAD;
      cnt_q   <= 4'd0;
      rnd_q   <= 6'd0;
      idx_q   <= 3'd0;
      final_q <= 1'b0;
      ov_q    <= 1'b0;
      hash_q  <= InitHash;
    end else begin
      state_q <= state_d;
      // A new word loads the output register; otherwise it empties once taken.
      ov_q    <= emit_go | (ov_q & ~out_ready_i);
      unique case (state_q)
        BACK_LOAD: begin
          if (pop_o) begin
            cnt_q   <= cnt_base + 4'd1;
            final_q <= pop_data_i.last;
            rnd_q   <= 6'd0;
            if (pop_data_i.start) begin
              hash_q <= InitHash;
            end
          end
        end
        BACK_ROUND: rnd_q <= rnd_q + 6'd1;
        BACK_ADD: begin
          idx_q <= 3'd0;
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + var_q[i];
          end
        end
        BACK_EMIT: begin
          if (emit_go) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              hash_q <= InitHash;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= pop_data_i.word;
      if (cnt_base == 4'd15) begin
        var_q <= hash_q;
      end
    end else if (state_q == BACK_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= ws;
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
    if (emit_go) begin
      od_q <= hash_q[idx_q];
      oi_q <= idx_q;
      ol_q <= (idx_q == 3'd7);
    end
  end

  assign out_valid_o   = ov_q;
  assign digest_word_o = od_q;
  assign word_index_o  = oi_q;
  assign last_word_o   = ol_q;

endmodule

@@ design/sha256_hash_engine.sv @@
// Top level of the streaming SHA-256 hash engine.
//
// Usage: each request on in_i carries one big-endian 32-bit message word, a
// start flag that begins a new message, an end flag on the final word and the
// count of valid bytes on that final word. After the final word the block
// sends the eight digest words on out_o, most significant first, with
// word_index 0..7 and last_word set on the eighth.
// Throughput: the front end takes one request per cycle while its queue has
// room and it is not padding. The back end loads 16 words and then runs one
// compression round per cycle; the single round unit limits the throughput.
// At reset the chaining value holds the standard initial hash and the length
// count is zero. When the receiver stalls, the digest word holds in its output
// register, the back end stops, the queue fills and the front end lowers ready.
module sha256_hash_engine import sha256_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  logic      push, full, pop, empty;
  blk_word_t push_data, pop_data;

  sha256_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .message_word_i  (in_i.message_word),
    .valid_bytes_i   (in_i.valid_bytes),
    .message_start_i (in_i.message_start),
    .message_end_i   (in_i.message_end),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  sha256_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  sha256_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

`ifndef ASSERT_OFF
  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("push into full queue");

  // The back end never takes from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from empty queue");

  // The eighth digest word, and only it, is flagged last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_word == (out_o.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // After a final request the front end is busy padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.message_end) |=> !in_i.ready)
    else $error("request taken during padding");
`endif

endmodule
